FILE: rtl/core/sum_threshold_flagger_with_gaps_core_defines.svh
// Assertion macros shared by the sum-threshold flagger RTL.
`ifndef SUM_THRESHOLD_FLAGGER_WITH_GAPS_CORE_DEFINES_SVH
`define SUM_THRESHOLD_FLAGGER_WITH_GAPS_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define STF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/stf_pkg.sv
// Shared widths, defaults and register indexes of the sum-threshold flagger.
`default_nettype none

package stf_pkg;

  // Default parameter values.
  localparam int unsigned MAX_WINDOW_DEF = 256;
  localparam int unsigned ROW_WIDTH_DEF  = 4096;

  // Field widths.
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned THR_W      = 32;
  localparam int unsigned WLEN_W     = 9;
  localparam int unsigned START_W    = 12;
  localparam int unsigned FCNT_W     = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 1'd1;

  // Register reset values.
  localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd1;
  localparam logic [THR_W-1:0]  THR_RESET  = 32'd655360;

endpackage

`default_nettype wire

FILE: rtl/core/stf_in_if.sv
// Sample input channel of the sum-threshold flagger.
`default_nettype none

interface stf_in_if import stf_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sample_value;
  logic                      already_flagged;
  logic                      sample_missing;
  logic                      row_end;

  modport source (output valid, sample_value, already_flagged, sample_missing, row_end,
                  input ready);
  modport sink   (input valid, sample_value, already_flagged, sample_missing, row_end,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/stf_out_if.sv
// Flag range output channel of the sum-threshold flagger.
`default_nettype none

interface stf_out_if import stf_pkg::*;;
  logic               valid;
  logic               ready;
  logic [START_W-1:0] flag_start;
  logic [FCNT_W-1:0]  flag_count;

  modport source (output valid, flag_start, flag_count, input ready);
  modport sink   (input valid, flag_start, flag_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/stf_cfg_if.sv
// Configuration write channel of the sum-threshold flagger.
`default_nettype none

interface stf_cfg_if import stf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/stf_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module stf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/sum_threshold_flagger_with_gaps_core.sv
// Sum-threshold flagger core: sliding window sum over a row stream with gaps.
//
// sample_i carries one sample word per handshake: value, already-flagged bit,
// missing bit and row-end mark. flag_o carries zero or one flag range word
// per sample: first column and number of columns to flag. cfg_i writes
// window_length (index 0, also empties the window) and threshold (index 1);
// it is always ready; the user must use it only while the block is idle,
// which the block does not enforce. The window is a ring RAM of MAX_WINDOW
// entries; each non-missing sample writes at the tail and, once the window
// is full, reads the oldest entry at the head, so one sample is taken every
// cycle unless flag_o stalls; the single RAM write and read port set that
// rate. Flag stages: RAM read and sum, magnitude and limit product, compare.
// After reset the window is empty, window_length is 1 and threshold is 10.0.
// The RAM needs no clearing pass: only entries written since the last clear
// are read. When flag_o stalls, the whole pipeline holds and sample_i.ready
// drops until the waiting word is taken.
`default_nettype none

`include "sum_threshold_flagger_with_gaps_core_defines.svh"

module sum_threshold_flagger_with_gaps_core import stf_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int unsigned ROW_WIDTH  = ROW_WIDTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  stf_cfg_if.sink  cfg_i,
  stf_in_if.sink   sample_i,
  stf_out_if.source flag_o
);

  localparam int unsigned AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned COL_W = $clog2(ROW_WIDTH);
  localparam int unsigned SUM_W = VALUE_W + CNT_W;
  localparam int unsigned DW    = VALUE_W + 1 + COL_W;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      flagged;
    logic                      smp;
    logic                      pop;
    logic                      fwd;
    logic                      last;
    logic [COL_W-1:0]          col;
  } s1_t;

  // Configuration registers.
  logic [WLEN_W-1:0] wlen_q;
  logic [THR_W-1:0]  thr_q;
  logic              cfg_we;
  logic              cfg_clear;
  logic [CNT_W-1:0]  len;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;
  assign cfg_clear   = cfg_we && (cfg_i.index == REG_WINDOW_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WLEN_RESET;
      thr_q  <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_i.index)
        REG_WINDOW_LENGTH: wlen_q <= cfg_i.data[WLEN_W-1:0];
        REG_THRESHOLD:     thr_q  <= cfg_i.data[THR_W-1:0];
        default:           ;
      endcase
    end
  end

  // Effective window length: zero acts as one, large values saturate.
  always_comb begin
    if (wlen_q == '0) begin
      len = CNT_W'(1);
    end else if (32'(wlen_q) > 32'(MAX_WINDOW)) begin
      len = CNT_W'(MAX_WINDOW);
    end else begin
      len = CNT_W'(wlen_q);
    end
  end

  // Pipeline advance: everything moves unless a flag word waits.
  logic out_valid_q;
  logic adv;
  logic acc;

  assign adv            = !out_valid_q || flag_o.ready;
  assign sample_i.ready = adv;
  assign acc            = sample_i.valid && sample_i.ready;

  // Stage 0: ring pointers, column counter, RAM write and head read.
  logic [CNT_W-1:0] fill_q;
  logic [AW-1:0]    head_q;
  logic [COL_W-1:0] col_q;
  logic [AW:0]      tail_sum;
  logic [AW-1:0]    tail;
  logic [AW-1:0]    head_nxt;
  logic             smp0;
  logic             pop0;
  logic             fwd0;
  logic             last0;

  assign smp0     = !sample_i.sample_missing;
  assign tail_sum = {1'b0, head_q} + (AW + 1)'(fill_q);
  assign tail     = (tail_sum >= (AW + 1)'(MAX_WINDOW)) ?
                    AW'(tail_sum - (AW + 1)'(MAX_WINDOW)) : tail_sum[AW-1:0];
  assign head_nxt = (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);
  assign pop0     = smp0 && ((fill_q + CNT_W'(1)) >= len);
  // The oldest entry is the one being written when the window was empty.
  assign fwd0     = pop0 && (fill_q == '0);
  assign last0    = sample_i.row_end || (col_q == COL_W'(ROW_WIDTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      head_q <= '0;
      col_q  <= '0;
    end else if (cfg_clear) begin
      fill_q <= '0;
      head_q <= '0;
    end else if (acc) begin
      if (last0) begin
        fill_q <= '0;
        head_q <= '0;
        col_q  <= '0;
      end else begin
        col_q <= col_q + COL_W'(1);
        if (smp0) begin
          if (pop0) begin
            head_q <= head_nxt;
          end else begin
            fill_q <= fill_q + CNT_W'(1);
          end
        end
      end
    end
  end

  logic [DW-1:0] rdata;

  stf_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_WINDOW)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (acc && smp0),
    .waddr_i (tail),
    .wdata_i ({sample_i.sample_value, sample_i.already_flagged, col_q}),
    .re_i    (acc && pop0),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  // Stage 1 registers.
  logic s1_valid_q;
  s1_t  s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q.value   <= sample_i.sample_value;
      s1_q.flagged <= sample_i.already_flagged;
      s1_q.smp     <= smp0;
      s1_q.pop     <= pop0;
      s1_q.fwd     <= fwd0;
      s1_q.last    <= last0;
      s1_q.col     <= col_q;
    end
  end

  // Stage 1: add the new sample, test setup, remove the oldest sample.
  logic signed [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]          cnt_q;
  logic signed [VALUE_W-1:0] old_value;
  logic                      old_flagged;
  logic [COL_W-1:0]          old_col;
  logic signed [SUM_W-1:0]   add_v;
  logic signed [SUM_W-1:0]   sub_v;
  logic signed [SUM_W-1:0]   sum_pre;
  logic [CNT_W-1:0]          cnt_pre;
  logic                      add_en;
  logic                      sub_en;
  logic                      test1;
  logic [COL_W:0]            span;
  logic                      s1_go;

  assign s1_go       = s1_valid_q && adv;
  assign old_value   = s1_q.fwd ? s1_q.value   : $signed(rdata[DW-1 -: VALUE_W]);
  assign old_flagged = s1_q.fwd ? s1_q.flagged : rdata[COL_W];
  assign old_col     = s1_q.fwd ? s1_q.col     : rdata[COL_W-1:0];
  assign add_en      = s1_q.smp && !s1_q.flagged;
  assign sub_en      = s1_q.pop && !old_flagged;
  assign add_v       = add_en ? SUM_W'(s1_q.value) : '0;
  assign sub_v       = sub_en ? SUM_W'(old_value) : '0;
  assign sum_pre     = sum_q + add_v;
  assign cnt_pre     = cnt_q + CNT_W'(add_en);
  assign test1       = s1_q.pop && (cnt_pre != '0);
  assign span        = {1'b0, s1_q.col} - {1'b0, old_col} + (COL_W + 1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cfg_clear) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (s1_go) begin
      if (s1_q.last) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_pre - sub_v;
        cnt_q <= cnt_pre - CNT_W'(sub_en);
      end
    end
  end

  // Stage 2 registers: sum and count at the test, flag range.
  logic                    s2_valid_q;
  logic signed [SUM_W-1:0] s2_sum_q;
  logic [CNT_W-1:0]        s2_cnt_q;
  logic [START_W-1:0]      s2_start_q;
  logic [FCNT_W-1:0]       s2_fcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && test1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_sum_q   <= sum_pre;
      s2_cnt_q   <= cnt_pre;
      s2_start_q <= START_W'(old_col);
      s2_fcnt_q  <= FCNT_W'(span);
    end
  end

  // Stage 2: magnitude of the sum and threshold times count.
  logic                    s3_valid_q;
  logic [SUM_W-1:0]        s3_mag_q;
  logic [SUM_W-1:0]        s3_lim_q;
  logic [START_W-1:0]      s3_start_q;
  logic [FCNT_W-1:0]       s3_fcnt_q;
  logic [SUM_W-1:0]        mag2;
  logic [SUM_W-1:0]        lim2;

  assign mag2 = s2_sum_q[SUM_W-1] ? SUM_W'(-s2_sum_q) : SUM_W'(s2_sum_q);
  assign lim2 = SUM_W'(thr_q) * SUM_W'(s2_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      s3_mag_q   <= mag2;
      s3_lim_q   <= lim2;
      s3_start_q <= s2_start_q;
      s3_fcnt_q  <= s2_fcnt_q;
    end
  end

  // Stage 3: compare and load the output register.
  logic               hit3;
  logic [START_W-1:0] out_start_q;
  logic [FCNT_W-1:0]  out_fcnt_q;

  assign hit3 = s3_mag_q > s3_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s3_valid_q && hit3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_valid_q) begin
      out_start_q <= s3_start_q;
      out_fcnt_q  <= s3_fcnt_q;
    end
  end

  assign flag_o.valid      = out_valid_q;
  assign flag_o.flag_start = out_start_q;
  assign flag_o.flag_count = out_fcnt_q;

  // Assertions.
  `STF_ASSERT_IMPL(a_fill_below_depth, 1'b1, fill_q < CNT_W'(MAX_WINDOW),
                   "window fill reached the ring depth")
  `STF_ASSERT_IMPL(a_fwd_only_len_one, s1_valid_q && s1_q.fwd, len == CNT_W'(1),
                   "head forwarding with a window longer than one")
  `STF_ASSERT_NEXT(a_accept_to_stage1, acc, s1_valid_q,
                   "accepted word did not reach stage one")

endmodule

`default_nettype wire

FILE: tb/sv/stf_flag_checker.sv
`timescale 1ns / 100ps
// Flag range checker: follows the sample stream, predicts the flag ranges and compares them.
module stf_flag_checker import stf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  stf_cfg_if   cfg_ch,
  stf_in_if    sample_ch,
  stf_out_if   flag_ch,
  output int   fail_count,
  output int   pending_count,
  output int   samples_seen,
  output int   row_ends_seen,
  output int   flags_seen,
  output int   writes_seen
);

  localparam int unsigned RING        = MAX_WINDOW_DEF;
  localparam int unsigned ROW_LEN     = ROW_WIDTH_DEF;
  localparam int          MAX_REPORTS = 40;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [FCNT_W-1:0]  count;
  } flag_range_t;

  // Flag ranges predicted but not yet seen on the output, oldest first.
  flag_range_t pending_ranges [$];

  // Register copies.
  logic [WLEN_W-1:0] wlen_q;
  logic [THR_W-1:0]  thr_q;

  // Window ring and running statistics.
  logic signed [VALUE_W-1:0] ring_value   [RING];
  logic                      ring_flagged [RING];
  int unsigned               ring_column  [RING];
  int unsigned               fill_q;
  int unsigned               head_q;
  int unsigned               unflagged_q;
  int unsigned               column_q;
  longint                    sum_q;

  function automatic void empty_window();
    fill_q      = 0;
    head_q      = 0;
    sum_q       = 0;
    unflagged_q = 0;
  endfunction

  function automatic void report_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: %s", $time, msg);
    end else if (fail_count == MAX_REPORTS + 1) begin
      $display("%0t: further mismatches are not shown", $time);
    end
  endfunction

  // Takes one sample word into the window and queues the flag range it raises, if any.
  function automatic void advance_window(input logic signed [VALUE_W-1:0] value,
                                         input logic flagged, input logic missing,
                                         input logic last);
    int unsigned col;
    int unsigned len;
    int unsigned tail;
    int unsigned oldest;
    longint      mag;
    longint      limit;
    flag_range_t rng;
    col = column_q;
    // A zero length acts as one, lengths above the ring size saturate.
    len = (wlen_q == 0) ? 1 : ((wlen_q > RING) ? RING : wlen_q);
    if (!missing) begin
      tail                = (head_q + fill_q) % RING;
      ring_value[tail]    = value;
      ring_flagged[tail]  = flagged;
      ring_column[tail]   = col;
      if (!flagged) begin
        sum_q += longint'(value);
        unflagged_q++;
      end
      fill_q++;
      // A full window is tested, then its oldest entry leaves.
      if (fill_q >= len) begin
        oldest = head_q;
        if (unflagged_q > 0) begin
          mag   = (sum_q < 0) ? -sum_q : sum_q;
          limit = longint'(thr_q) * longint'(unflagged_q);
          if (mag > limit) begin
            rng.start = START_W'(ring_column[oldest]);
            rng.count = FCNT_W'(col - ring_column[oldest] + 1);
            pending_ranges.push_back(rng);
          end
        end
        if (!ring_flagged[oldest]) begin
          sum_q -= longint'(ring_value[oldest]);
          unflagged_q--;
        end
        fill_q--;
        head_q = (oldest + 1) % RING;
      end
    end
    // A row end, or running past the last column, starts a new row.
    if (last || col + 1 >= ROW_LEN) begin
      empty_window();
      column_q = 0;
    end else begin
      column_q = col + 1;
    end
  endfunction

  // Observe all three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    flag_range_t got;
    flag_range_t want;
    if (!rst_ni) begin
      wlen_q = WLEN_RESET;
      thr_q  = THR_RESET;
      empty_window();
      column_q = 0;
      pending_ranges.delete();
      fail_count    = 0;
      pending_count = 0;
      samples_seen  = 0;
      row_ends_seen = 0;
      flags_seen    = 0;
      writes_seen   = 0;
    end else begin
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        writes_seen++;
        if (cfg_ch.index == REG_WINDOW_LENGTH) begin
          wlen_q = cfg_ch.data[WLEN_W-1:0];
          empty_window();
        end else if (cfg_ch.index == REG_THRESHOLD) begin
          thr_q = cfg_ch.data[THR_W-1:0];
        end
      end
      if (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) begin
        samples_seen++;
        if (sample_ch.row_end) begin
          row_ends_seen++;
        end
        advance_window(sample_ch.sample_value, sample_ch.already_flagged,
                       sample_ch.sample_missing, sample_ch.row_end);
      end
      // Expectations are queued before popping, so the oldest one is compared.
      if (flag_ch.valid === 1'b1 && flag_ch.ready === 1'b1) begin
        flags_seen++;
        got.start = flag_ch.flag_start;
        got.count = flag_ch.flag_count;
        if (pending_ranges.size() == 0) begin
          report_failure($sformatf("unexpected flag range: start %0d count %0d",
                                   got.start, got.count));
        end else begin
          want = pending_ranges.pop_front();
          if (got.start !== want.start || got.count !== want.count) begin
            report_failure($sformatf(
              "flag range mismatch: expected start %0d count %0d, got start %0d count %0d",
              want.start, want.count, got.start, got.count));
          end
        end
      end
      pending_count = pending_ranges.size();
    end
  end

endmodule

FILE: tb/sv/tb_sum_threshold_flagger_with_gaps_core.sv
`timescale 1ns / 100ps
// Testbench top for the sum-threshold flagger: clock, reset, stimulus and verdict.
module tb_sum_threshold_flagger_with_gaps_core;
  import stf_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES  = 16;
  localparam int NUM_PHASES   = 9;
  localparam int UNIT         = 65536;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTY, STALL_TOGGLE} stall_mode_e;

  logic clk_i;
  logic rst_ni;

  stf_cfg_if cfg_bus ();
  stf_in_if  sample_bus ();
  stf_out_if flag_bus ();

  int fail_count;
  int pending_count;
  int samples_seen;
  int row_ends_seen;
  int flags_seen;
  int writes_seen;
  int cycle_count = 0;
  int burst_left;
  int gap_max;

  // Per phase: window length word, threshold, sample count, longest row, longest gap.
  logic [31:0] phase_wlen  [NUM_PHASES] = '{32'd1, 32'd2, 32'd4, 32'd8, 32'd16, 32'h0000_0105,
                                            32'd511, 32'hFFFF_FE05, 32'd256};
  logic [31:0] phase_thr   [NUM_PHASES] = '{32'd655360, 32'd0, 32'd327680, 32'hFFFF_FFFF,
                                            32'd196608, 32'd131072, 32'd65536, 32'd262144,
                                            32'd0};
  int          phase_items [NUM_PHASES] = '{200, 150, 200, 150, 200, 350, 250, 200, 150};
  int          phase_row   [NUM_PHASES] = '{20, 20, 30, 40, 60, 500, 400, 25, 300};
  int          phase_gap   [NUM_PHASES] = '{1, 4, 2, 6, 3, 2, 1, 5, 3};

  sum_threshold_flagger_with_gaps_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .sample_i (sample_bus),
    .flag_o   (flag_bus)
  );

  stf_flag_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_ch        (cfg_bus),
    .sample_ch     (sample_bus),
    .flag_ch       (flag_bus),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .samples_seen  (samples_seen),
    .row_ends_seen (row_ends_seen),
    .flags_seen    (flags_seen),
    .writes_seen   (writes_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The flag receiver switches between stall patterns: none, random, bursty and toggling.
  initial begin : flag_stall
    stall_mode_e mode;
    int          left;
    int          run;
    flag_bus.ready = 1'b0;
    mode           = STALL_NONE;
    left           = 0;
    run            = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        left = $urandom_range(20, 120);
      end
      left--;
      case (mode)
        STALL_NONE: begin
          flag_bus.ready = 1'b1;
        end
        STALL_RANDOM: begin
          flag_bus.ready = ($urandom_range(0, 3) != 0);
        end
        STALL_BURSTY: begin
          if (run <= 0) begin
            flag_bus.ready = ~flag_bus.ready;
            run            = $urandom_range(1, 12);
          end
          run--;
        end
        default: begin
          flag_bus.ready = ~flag_bus.ready;
        end
      endcase
    end
  end

  // Random payload while no word is offered.
  task automatic scramble_sample_fields();
    sample_bus.sample_value    = $urandom;
    sample_bus.already_flagged = $urandom_range(0, 1);
    sample_bus.sample_missing  = $urandom_range(0, 1);
    sample_bus.row_end         = $urandom_range(0, 1);
  endtask

  // Offers one sample word, waits for it to be taken, then keeps to the burst pattern.
  task automatic send_sample(input logic [VALUE_W-1:0] value, input logic flagged,
                             input logic missing, input logic last);
    int gap;
    @(negedge clk_i);
    sample_bus.valid           = 1'b1;
    sample_bus.sample_value    = value;
    sample_bus.already_flagged = flagged;
    sample_bus.sample_missing  = missing;
    sample_bus.row_end         = last;
    do @(posedge clk_i); while (sample_bus.ready !== 1'b1);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, gap_max);
      @(negedge clk_i);
      sample_bus.valid = 1'b0;
      scramble_sample_fields();
      repeat (gap - 1) begin
        @(negedge clk_i);
        scramble_sample_fields();
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 15);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  // Stops the sample stream and waits until the block has drained.
  task automatic settle();
    @(negedge clk_i);
    sample_bus.valid = 1'b0;
    while (pending_count != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Row content: a per-row mean with noise, and an occasional full-range spike.
  function automatic logic [VALUE_W-1:0] row_sample(input int mean, input int amp);
    int noise;
    if ($urandom_range(0, 31) == 0) begin
      return $urandom;
    end
    noise = int'($urandom_range(0, 2 * amp * UNIT)) - amp * UNIT;
    return mean * UNIT + noise;
  endfunction

  // Sends rows of random length until n_items words have been taken.
  task automatic run_rows(input int n_items, input int max_row, input bit allow_end);
    int sent;
    int len;
    int mean;
    int amp;
    int miss_w;
    int flag_w;
    int i;
    bit last;
    sent = 0;
    while (sent < n_items) begin
      len    = $urandom_range(1, max_row);
      mean   = int'($urandom_range(0, 48)) - 24;
      amp    = $urandom_range(0, 16);
      miss_w = $urandom_range(0, 4);
      flag_w = $urandom_range(0, 4);
      for (i = 0; i < len && sent < n_items; i++) begin
        last = allow_end && (i == len - 1) && ($urandom_range(0, 7) != 0);
        send_sample(row_sample(mean, amp), $urandom_range(0, 15) < flag_w,
                    $urandom_range(0, 15) < miss_w, last);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int p;
    rst_ni           = 1'b0;
    sample_bus.valid = 1'b0;
    scramble_sample_fields();
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = REG_WINDOW_LENGTH;
    cfg_bus.data     = '0;
    burst_left       = 0;
    gap_max          = 2;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset setting, one-sample window at 10.0: the limit itself, just above it,
    // full-scale values, an excluded sample, a skipped sample and row ends.
    send_sample(32'd655360, 1'b0, 1'b0, 1'b0);
    send_sample(32'd655361, 1'b0, 1'b0, 1'b0);
    send_sample(-32'sd655361, 1'b0, 1'b0, 1'b0);
    send_sample(-32'sd655360, 1'b0, 1'b0, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
    send_sample(32'h8000_0000, 1'b0, 1'b0, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0);
    send_sample(32'd0, 1'b0, 1'b0, 1'b1);
    send_sample(32'd1000000, 1'b0, 1'b1, 1'b1);

    // Zero window length acts as one; zero threshold flags any nonzero sum.
    settle();
    write_reg(REG_WINDOW_LENGTH, 32'd0);
    write_reg(REG_THRESHOLD, 32'd0);
    send_sample(32'd0, 1'b0, 1'b0, 1'b0);
    send_sample(32'd1, 1'b0, 1'b0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);

    // Window of three with stray upper bits in the length word: the range spans
    // the missing columns, and a short row never flags.
    settle();
    write_reg(REG_WINDOW_LENGTH, 32'hABCD_E003);
    write_reg(REG_THRESHOLD, 32'd65536);
    send_sample(32'd131072, 1'b0, 1'b0, 1'b0);
    send_sample(32'd131072, 1'b0, 1'b1, 1'b0);
    send_sample(32'd131072, 1'b0, 1'b1, 1'b0);
    send_sample(32'd131072, 1'b1, 1'b0, 1'b0);
    send_sample(32'd131072, 1'b0, 1'b0, 1'b0);
    send_sample(-32'sd655360, 1'b0, 1'b0, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1);

    // Random rows over a spread of window lengths and thresholds, extremes included.
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(REG_WINDOW_LENGTH, phase_wlen[p]);
      write_reg(REG_THRESHOLD, phase_thr[p]);
      gap_max = phase_gap[p];
      run_rows(phase_items[p], phase_row[p], 1'b1);
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Run covered %0d samples with %0d row ends and %0d register writes,",
             samples_seen, row_ends_seen, writes_seen);
    $display("and compared %0d flag ranges, %0d of them in error.", flags_seen, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
